>>> design/assert_macros.svh
// assertion macros shared by the checker files
// clocked on clk, disabled while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TBS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TBS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/tbs_pkg.sv
// shared types and codes of the token budget batch scheduler
// no dependencies
`default_nettype none

package tbs_pkg;

  localparam logic [1:0] REQ_SUBMIT   = 2'd0;
  localparam logic [1:0] REQ_SCHEDULE = 2'd1;
  localparam logic [1:0] REQ_TOKEN    = 2'd2;
  localparam logic [1:0] REQ_COLLECT  = 2'd3;

  localparam logic [2:0] KIND_ACCEPTED    = 3'd0;
  localparam logic [2:0] KIND_REJECTED    = 3'd1;
  localparam logic [2:0] KIND_DECODE_PICK = 3'd2;
  localparam logic [2:0] KIND_PREFILL     = 3'd3;
  localparam logic [2:0] KIND_BATCH_END   = 3'd4;
  localparam logic [2:0] KIND_TOKEN_DONE  = 3'd5;
  localparam logic [2:0] KIND_RETIRED     = 3'd6;
  localparam logic [2:0] KIND_COLLECT_END = 3'd7;

  localparam logic [1:0] ST_EMPTY   = 2'd0;
  localparam logic [1:0] ST_PREFILL = 2'd1;
  localparam logic [1:0] ST_DECODE  = 2'd2;
  localparam logic [1:0] ST_DONE    = 2'd3;

  localparam logic [0:0] CFG_TOKEN_BUDGET = 1'b0;
  localparam logic [0:0] CFG_SEQ_LIMIT    = 1'b1;

  localparam logic [15:0] BUDGET_RESET    = 16'd2048;
  localparam logic [4:0]  SEQ_LIMIT_RESET = 5'd16;
  localparam logic [19:0] TOTAL_MAX       = 20'hFFFFF;
  localparam logic [5:0]  PEND_MAX        = 6'd63;

  typedef enum logic [3:0] {
    S_IDLE, S_SUB, S_TOK, S_DEC, S_FETCH, S_ADM, S_BEND, S_COL, S_CEND
  } ctl_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_SUBMIT, OP_TOKEN, OP_DEC_STEP, OP_ADMIT,
    OP_BATCH_END, OP_COL_STEP, OP_COL_END
  } dp_op_t;

  typedef struct packed {
    logic   in_ready;
    dp_op_t op;
  } ctl_cmd_t;

  typedef struct packed {
    logic       out_free;
    logic [1:0] req_type;
    logic       walk_more;
    logic       adm_go;
  } dp_status_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [31:0]        req_id;
    logic [3:0]         slot_out;
    logic [15:0]        pick_tokens;
    logic [19:0]        batch_total;
    logic [15:0]        produced;
    logic [1:0]         slot_state;
    logic signed [31:0] token_echo;
    logic [5:0]         pending_count;
    logic               last;
  } out_item_t;

endpackage

`default_nettype wire

>>> design/tbs_channels.sv
// valid/ready channel interfaces for requests and results
// no dependencies
`default_nettype none

interface tbs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [15:0]        prompt_len;
  logic [15:0]        new_limit;
  logic [3:0]         slot_sel;
  logic signed [31:0] token_value;

  modport source (output valid, req_type, prompt_len, new_limit, slot_sel, token_value,
                  input ready);
  modport sink (input valid, req_type, prompt_len, new_limit, slot_sel, token_value,
                output ready);
endinterface

interface tbs_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [31:0]        req_id;
  logic [3:0]         slot_out;
  logic [15:0]        pick_tokens;
  logic [19:0]        batch_total;
  logic [15:0]        produced;
  logic [1:0]         slot_state;
  logic signed [31:0] token_echo;
  logic [5:0]         pending_count;
  logic               last;

  modport source (output valid, kind, req_id, slot_out, pick_tokens, batch_total, produced,
                  slot_state, token_echo, pending_count, last, input ready);
  modport sink (input valid, kind, req_id, slot_out, pick_tokens, batch_total, produced,
                slot_state, token_echo, pending_count, last, output ready);
endinterface

`default_nettype wire

>>> design/tbs_ctrl.sv
// controller state machine of the batch scheduler
// depends on tbs_pkg
`default_nettype none

module tbs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  tbs_pkg::dp_status_t  status,
  output tbs_pkg::ctl_cmd_t    cmd
);
  import tbs_pkg::*;

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (status.req_type)
            REQ_SUBMIT:   state_next = S_SUB;
            REQ_SCHEDULE: state_next = S_DEC;
            REQ_TOKEN:    state_next = S_TOK;
            REQ_COLLECT:  state_next = S_COL;
          endcase
        end
      end
      S_SUB, S_TOK, S_BEND, S_CEND: begin
        if (status.out_free) state_next = S_IDLE;
      end
      S_DEC: begin
        if (!status.walk_more) state_next = S_FETCH;
      end
      S_FETCH: state_next = S_ADM;
      S_ADM: begin
        if (!status.adm_go) state_next = S_BEND;
        else if (status.out_free) state_next = S_FETCH;
      end
      S_COL: begin
        if (!status.walk_more) state_next = S_CEND;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.in_ready = (state == S_IDLE);
    cmd.op       = OP_NONE;
    unique case (state)
      S_IDLE:  if (in_valid) cmd.op = OP_LOAD;
      S_SUB:   if (status.out_free) cmd.op = OP_SUBMIT;
      S_TOK:   if (status.out_free) cmd.op = OP_TOKEN;
      S_DEC:   if (status.walk_more && status.out_free) cmd.op = OP_DEC_STEP;
      S_FETCH: cmd.op = OP_NONE;
      S_ADM:   if (status.adm_go && status.out_free) cmd.op = OP_ADMIT;
      S_BEND:  if (status.out_free) cmd.op = OP_BATCH_END;
      S_COL:   if (status.walk_more && status.out_free) cmd.op = OP_COL_STEP;
      S_CEND:  if (status.out_free) cmd.op = OP_COL_END;
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

>>> design/tbs_datapath.sv
// datapath of the batch scheduler: wait queue, slot table, order list, result register
// depends on tbs_pkg
`default_nettype none

module tbs_datapath #(
  parameter int WAIT_DEPTH = 16,
  parameter int RUN_SLOTS  = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic [1:0]          req_type,
  input  logic [15:0]         prompt_len,
  input  logic [15:0]         new_limit,
  input  logic [3:0]          slot_sel,
  input  logic signed [31:0]  token_value,
  input  tbs_pkg::ctl_cmd_t   cmd,
  output tbs_pkg::dp_status_t status,
  input  logic                out_ready,
  output logic                out_valid,
  output tbs_pkg::out_item_t  out_item
);
  import tbs_pkg::*;

  localparam int AW      = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int WCW     = $clog2(WAIT_DEPTH + 1);
  localparam int SW      = (RUN_SLOTS > 1) ? $clog2(RUN_SLOTS) : 1;
  localparam int CW      = $clog2(RUN_SLOTS + 1);
  localparam int PSW_RAW = $clog2(WAIT_DEPTH + RUN_SLOTS + 2);
  localparam int PSW     = (PSW_RAW > 7) ? PSW_RAW : 7;

  // configuration
  logic [15:0] token_budget;
  logic [4:0]  seq_limit;

  // wait queue
  logic [63:0]    fifo_mem [WAIT_DEPTH];
  logic [63:0]    head_q;
  logic [AW-1:0]  head, tail;
  logic [WCW-1:0] wait_count;
  logic [31:0]    id_counter;

  // running slots
  logic [1:0]    slot_state [RUN_SLOTS];
  logic [31:0]   slot_ident [RUN_SLOTS];
  logic [15:0]   slot_limit [RUN_SLOTS];
  logic [15:0]   slot_made  [RUN_SLOTS];
  logic [SW-1:0] order      [RUN_SLOTS];
  logic [CW-1:0] run_count, done_count;

  // per-item working registers
  logic [15:0]        plen_q, nlim_q;
  logic [3:0]         sel_q;
  logic signed [31:0] tok_q;
  logic [5:0]         pend_q;
  logic [CW-1:0]      rank, walk_lim, next_rank;
  logic signed [17:0] budget;
  logic [19:0]        total;
  logic               prefill_seen;

  // derived
  logic           wait_full, budget_pos, need_over, cap_ok;
  logic [SW-1:0]  cur_slot, free_slot, tok_idx;
  logic [1:0]     cur_state, tok_old, tok_new;
  logic           tok_hit;
  logic [15:0]    made_inc, head_need;
  logic [20:0]    total_sum;
  logic [PSW-1:0] pend_raw;
  logic           emit;
  out_item_t      item_d;

  assign wait_full  = int'(wait_count) >= WAIT_DEPTH;
  assign budget_pos = budget > 18'sd0;
  assign head_need  = head_q[47:32];
  assign need_over  = $signed({2'b00, head_need}) > budget;
  assign cap_ok     = (int'(run_count) < RUN_SLOTS) && (int'(run_count) < int'(seq_limit));
  assign cur_slot   = order[rank[SW-1:0]];
  assign cur_state  = slot_state[cur_slot];
  assign total_sum  = {1'b0, total} + 21'(head_need);

  assign tok_idx  = SW'(sel_q);
  assign tok_hit  = (int'(sel_q) < RUN_SLOTS) && (slot_state[tok_idx] != ST_EMPTY);
  assign tok_old  = slot_state[tok_idx];
  assign made_inc = (slot_made[tok_idx] == 16'hFFFF) ? 16'hFFFF : slot_made[tok_idx] + 16'd1;

  always_comb begin
    if (made_inc >= slot_limit[tok_idx]) tok_new = ST_DONE;
    else if (tok_old == ST_PREFILL) tok_new = ST_DECODE;
    else tok_new = tok_old;
  end

  // lowest empty slot
  always_comb begin
    free_slot = '0;
    for (int s = RUN_SLOTS - 1; s >= 0; s--) begin
      if (slot_state[s] == ST_EMPTY) free_slot = SW'(s);
    end
  end

  // pending count after the item, fixed when it is loaded
  always_comb begin
    pend_raw = PSW'(wait_count) + PSW'(run_count);
    if (req_type == REQ_SUBMIT && !wait_full) pend_raw = pend_raw + PSW'(1);
    if (req_type == REQ_COLLECT) pend_raw = pend_raw - PSW'(done_count);
  end

  assign status.out_free  = !out_valid || out_ready;
  assign status.req_type  = req_type;
  assign status.walk_more = rank < walk_lim;
  assign status.adm_go    = (wait_count != '0) && cap_ok && budget_pos &&
                            !(need_over && prefill_seen);

  // result build
  always_comb begin
    emit                 = 1'b0;
    item_d               = '0;
    item_d.pending_count = pend_q;
    unique case (cmd.op)
      OP_SUBMIT: begin
        emit        = 1'b1;
        item_d.last = 1'b1;
        if (wait_full) begin
          item_d.kind = KIND_REJECTED;
        end else begin
          item_d.kind   = KIND_ACCEPTED;
          item_d.req_id = id_counter;
        end
      end
      OP_TOKEN: begin
        emit              = 1'b1;
        item_d.kind       = KIND_TOKEN_DONE;
        item_d.slot_out   = sel_q;
        item_d.token_echo = tok_q;
        item_d.last       = 1'b1;
        if (tok_hit) begin
          item_d.req_id     = slot_ident[tok_idx];
          item_d.produced   = made_inc;
          item_d.slot_state = tok_new;
        end
      end
      OP_DEC_STEP: begin
        if (cur_state == ST_DECODE && budget_pos) begin
          emit               = 1'b1;
          item_d.kind        = KIND_DECODE_PICK;
          item_d.req_id      = slot_ident[cur_slot];
          item_d.slot_out    = 4'(cur_slot);
          item_d.pick_tokens = 16'd1;
          item_d.produced    = slot_made[cur_slot];
          item_d.slot_state  = ST_DECODE;
        end
      end
      OP_ADMIT: begin
        emit               = 1'b1;
        item_d.kind        = KIND_PREFILL;
        item_d.req_id      = head_q[31:0];
        item_d.slot_out    = 4'(free_slot);
        item_d.pick_tokens = head_need;
        item_d.slot_state  = ST_PREFILL;
      end
      OP_BATCH_END: begin
        emit               = 1'b1;
        item_d.kind        = KIND_BATCH_END;
        item_d.batch_total = total;
        item_d.last        = 1'b1;
      end
      OP_COL_STEP: begin
        if (cur_state == ST_DONE) begin
          emit              = 1'b1;
          item_d.kind       = KIND_RETIRED;
          item_d.req_id     = slot_ident[cur_slot];
          item_d.slot_out   = 4'(cur_slot);
          item_d.produced   = slot_made[cur_slot];
          item_d.slot_state = ST_DONE;
        end
      end
      OP_COL_END: begin
        emit        = 1'b1;
        item_d.kind = KIND_COLLECT_END;
        item_d.last = 1'b1;
      end
      default: emit = 1'b0;
    endcase
  end

  // wait queue storage
  always_ff @(posedge clk) begin
    if (cmd.op == OP_SUBMIT && !wait_full) fifo_mem[tail] <= {nlim_q, plen_q, id_counter};
    head_q <= fifo_mem[head];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      token_budget <= BUDGET_RESET;
      seq_limit    <= SEQ_LIMIT_RESET;
      head         <= '0;
      tail         <= '0;
      wait_count   <= '0;
      id_counter   <= '0;
      run_count    <= '0;
      done_count   <= '0;
      out_valid    <= 1'b0;
      for (int s = 0; s < RUN_SLOTS; s++) slot_state[s] <= ST_EMPTY;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TOKEN_BUDGET: token_budget <= cfg_data;
          CFG_SEQ_LIMIT:    seq_limit    <= cfg_data[4:0];
        endcase
      end
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      unique case (cmd.op)
        OP_SUBMIT: begin
          if (!wait_full) begin
            tail       <= (tail == AW'(WAIT_DEPTH - 1)) ? '0 : tail + AW'(1);
            wait_count <= wait_count + WCW'(1);
            id_counter <= id_counter + 32'd1;
          end
        end
        OP_TOKEN: begin
          if (tok_hit) begin
            slot_state[tok_idx] <= tok_new;
            if (tok_new == ST_DONE && tok_old != ST_DONE) done_count <= done_count + CW'(1);
          end
        end
        OP_ADMIT: begin
          head                  <= (head == AW'(WAIT_DEPTH - 1)) ? '0 : head + AW'(1);
          wait_count            <= wait_count - WCW'(1);
          slot_state[free_slot] <= ST_PREFILL;
          run_count             <= run_count + CW'(1);
        end
        OP_COL_STEP: begin
          if (cur_state == ST_DONE) begin
            slot_state[cur_slot] <= ST_EMPTY;
            run_count            <= run_count - CW'(1);
            done_count           <= done_count - CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // payload and per-item working registers
  always_ff @(posedge clk) begin
    if (emit) out_item <= item_d;
    unique case (cmd.op)
      OP_LOAD: begin
        plen_q       <= prompt_len;
        nlim_q       <= new_limit;
        sel_q        <= slot_sel;
        tok_q        <= token_value;
        pend_q       <= (pend_raw > PSW'(PEND_MAX)) ? PEND_MAX : pend_raw[5:0];
        rank         <= '0;
        walk_lim     <= run_count;
        next_rank    <= '0;
        budget       <= $signed({2'b00, token_budget});
        total        <= '0;
        prefill_seen <= 1'b0;
      end
      OP_TOKEN: begin
        if (tok_hit) slot_made[tok_idx] <= made_inc;
      end
      OP_DEC_STEP: begin
        rank <= rank + CW'(1);
        if (cur_state == ST_DECODE && budget_pos) begin
          budget <= budget - 18'sd1;
          total  <= total + 20'd1;
        end
      end
      OP_ADMIT: begin
        slot_ident[free_slot]      <= head_q[31:0];
        slot_limit[free_slot]      <= head_q[63:48];
        slot_made[free_slot]       <= 16'd0;
        order[run_count[SW-1:0]]   <= free_slot;
        total                      <= total_sum[20] ? TOTAL_MAX : total_sum[19:0];
        budget                     <= budget - $signed({2'b00, head_need});
        prefill_seen               <= 1'b1;
      end
      OP_COL_STEP: begin
        rank <= rank + CW'(1);
        if (cur_state != ST_DONE) begin
          order[next_rank[SW-1:0]] <= cur_slot;
          next_rank                <= next_rank + CW'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> design/token_budget_batch_scheduler_unit.sv
// top level of the token budget batch scheduler
// depends on tbs_pkg, tbs_channels, tbs_ctrl, tbs_datapath
`default_nettype none

// Continuous-batching scheduler. Requests are submitted into a wait queue and
// get ids in order; a schedule step picks every decode slot in admission order
// (one token each) while the budget lasts, then admits queued requests as
// prefills into free slots, ending with a batch-end result carrying the total.
// Token events advance a slot from prefill to decode or to finished; collect
// retires finished slots and compacts the admission order. Items are handled
// one at a time. Schedule and collect walk the order list one slot per cycle
// while the output register is free to take a result, and schedule waits on
// the registered read of the queue head after each admission. The last result
// of an item may sit in the output register while the next item is taken. No
// clearing pass is needed after reset.
module token_budget_batch_scheduler_unit #(
  parameter int WAIT_DEPTH = 16,
  parameter int RUN_SLOTS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  tbs_in_if.sink      in_ch,
  tbs_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import tbs_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;
  out_item_t  item;
  logic       out_valid;

  // sequencing of one item at a time
  tbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .status   (status),
    .cmd      (cmd)
  );

  // queue, slot table and result register
  tbs_datapath #(
    .WAIT_DEPTH (WAIT_DEPTH),
    .RUN_SLOTS  (RUN_SLOTS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req_type    (in_ch.req_type),
    .prompt_len  (in_ch.prompt_len),
    .new_limit   (in_ch.new_limit),
    .slot_sel    (in_ch.slot_sel),
    .token_value (in_ch.token_value),
    .cmd         (cmd),
    .status      (status),
    .out_ready   (out_ch.ready),
    .out_valid   (out_valid),
    .out_item    (item)
  );

  // input transfer only while the controller is idle
  assign in_ch.ready = cmd.in_ready;

  // result channel straight from the output register
  assign out_ch.valid         = out_valid;
  assign out_ch.kind          = item.kind;
  assign out_ch.req_id        = item.req_id;
  assign out_ch.slot_out      = item.slot_out;
  assign out_ch.pick_tokens   = item.pick_tokens;
  assign out_ch.batch_total   = item.batch_total;
  assign out_ch.produced      = item.produced;
  assign out_ch.slot_state    = item.slot_state;
  assign out_ch.token_echo    = item.token_echo;
  assign out_ch.pending_count = item.pending_count;
  assign out_ch.last          = item.last;

endmodule

`default_nettype wire

>>> design/tbs_checker.sv
// port-level checks of the batch scheduler, bound to the top level
// depends on tbs_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module tbs_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_kind,
  input logic       out_last
);
  import tbs_pkg::*;

  `TBS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "stalled result dropped")
  `TBS_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after transfer")
  `TBS_ASSERT_IMP(a_idle_only_last, in_ready && out_valid, out_last, "idle with open run")
  `TBS_ASSERT_IMP(a_end_is_last, out_valid && (out_kind == KIND_BATCH_END || out_kind == KIND_COLLECT_END), out_last, "end without last")
  `TBS_ASSERT_IMP(a_pick_not_last, out_valid && (out_kind == KIND_DECODE_PICK || out_kind == KIND_PREFILL || out_kind == KIND_RETIRED), !out_last, "pick marked last")

endmodule

bind token_budget_batch_scheduler_unit tbs_checker u_tbs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.kind),
  .out_last  (out_ch.last)
);

`default_nettype wire
